FILE: hw/rtl/pbsc_pkg.sv
// ----------------------------------------------------------------------------
// pbsc_pkg
// Shared widths, codes and pipeline control types for the plane classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package pbsc_pkg;

  localparam int DATA_W = 32;
  localparam int PROD_W = 2 * DATA_W;
  localparam int K_W    = DATA_W + 2;
  localparam int FRAC_W = 16;
  localparam int ACC_W  = PROD_W + 4;
  localparam int IDX_W  = 2;

  localparam logic OP_BOX    = 1'b0;
  localparam logic OP_SPHERE = 1'b1;

  localparam logic [IDX_W-1:0] REG_NORMAL_X = 2'd0;
  localparam logic [IDX_W-1:0] REG_NORMAL_Y = 2'd1;
  localparam logic [IDX_W-1:0] REG_NORMAL_Z = 2'd2;
  localparam logic [IDX_W-1:0] REG_OFFSET_D = 2'd3;

  typedef enum logic [1:0] {
    CLS_FRONT        = 2'd0,
    CLS_BACK         = 2'd1,
    CLS_INTERSECTING = 2'd2
  } cls_t;

  // Load enables of the two stages inside each plane evaluator.
  typedef struct packed {
    logic s1;
    logic s2;
  } pbsc_adv_t;

endpackage

`default_nettype wire

FILE: hw/rtl/pbsc_plane_eval.sv
// ----------------------------------------------------------------------------
// pbsc_plane_eval
// Two-stage exact evaluation of n.p + k*2^16 with a sign test on the sum.
// ----------------------------------------------------------------------------
`default_nettype none

module pbsc_plane_eval (
  input  wire logic                             clk,
  input  wire pbsc_pkg::pbsc_adv_t              adv,
  input  wire logic signed [pbsc_pkg::DATA_W-1:0] nrm_x,
  input  wire logic signed [pbsc_pkg::DATA_W-1:0] nrm_y,
  input  wire logic signed [pbsc_pkg::DATA_W-1:0] nrm_z,
  input  wire logic signed [pbsc_pkg::DATA_W-1:0] pt_x,
  input  wire logic signed [pbsc_pkg::DATA_W-1:0] pt_y,
  input  wire logic signed [pbsc_pkg::DATA_W-1:0] pt_z,
  input  wire logic signed [pbsc_pkg::K_W-1:0]    k,
  output logic                                    gt_zero,
  output logic                                    lt_zero
);

  logic signed [pbsc_pkg::PROD_W-1:0] prod_x_nxt, prod_y_nxt, prod_z_nxt;
  logic signed [pbsc_pkg::PROD_W-1:0] prod_x_r, prod_y_r, prod_z_r;
  logic signed [pbsc_pkg::K_W-1:0]    k_r;
  logic signed [pbsc_pkg::ACC_W-1:0]  sum_a_nxt, sum_b_nxt, sum_a_r, sum_b_r;
  logic signed [pbsc_pkg::ACC_W-1:0]  total;

  assign prod_x_nxt = nrm_x * pt_x;
  assign prod_y_nxt = nrm_y * pt_y;
  assign prod_z_nxt = nrm_z * pt_z;

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      prod_x_r <= prod_x_nxt;
      prod_y_r <= prod_y_nxt;
      prod_z_r <= prod_z_nxt;
      k_r      <= k;
    end
  end

  assign sum_a_nxt = pbsc_pkg::ACC_W'(prod_x_r) + pbsc_pkg::ACC_W'(prod_y_r);
  assign sum_b_nxt = pbsc_pkg::ACC_W'(prod_z_r)
                   + pbsc_pkg::ACC_W'($signed({k_r, {pbsc_pkg::FRAC_W{1'b0}}}));

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      sum_a_r <= sum_a_nxt;
      sum_b_r <= sum_b_nxt;
    end
  end

  assign total   = sum_a_r + sum_b_r;
  assign lt_zero = total[pbsc_pkg::ACC_W-1];
  assign gt_zero = !total[pbsc_pkg::ACC_W-1] && (total != '0);

endmodule

`default_nettype wire

FILE: hw/rtl/plane_box_sphere_classifier_top.sv
// ----------------------------------------------------------------------------
// plane_box_sphere_classifier_top
// Classifies an axis-aligned box or a sphere against a configured plane.
// ----------------------------------------------------------------------------
// The plane normal and offset are written through the cfg channel (index 0 to
// 2 for the normal components, 3 for the offset); cfg_ready is always high.
// The user must make writes only while no item is in flight; not enforced.
// Each input transfer carries one shape and yields exactly one output
// transfer with its classification: front, back or intersecting.
// The pipeline has three register stages: six 32x32 products, two partial
// sums in each evaluator, then the final wide add with the sign tests
// feeding the output register. A new item is taken every cycle while the
// output is drained.
// When the receiver holds out_ready low, items stay in their stages; bubbles
// are squeezed out and in_ready drops only once all three stages are full.
// Synchronous reset clears the stage valid bits and sets the plane to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module plane_box_sphere_classifier_top (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic                                 in_operation,
  input  wire logic signed [pbsc_pkg::DATA_W-1:0]   in_lo_or_centre_x,
  input  wire logic signed [pbsc_pkg::DATA_W-1:0]   in_lo_or_centre_y,
  input  wire logic signed [pbsc_pkg::DATA_W-1:0]   in_lo_or_centre_z,
  input  wire logic signed [pbsc_pkg::DATA_W-1:0]   in_box_hi_x,
  input  wire logic signed [pbsc_pkg::DATA_W-1:0]   in_box_hi_y,
  input  wire logic signed [pbsc_pkg::DATA_W-1:0]   in_box_hi_z,
  input  wire logic signed [pbsc_pkg::DATA_W-1:0]   in_sphere_radius,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [1:0]                                out_classification,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [pbsc_pkg::IDX_W-1:0]           cfg_index,
  input  wire logic [pbsc_pkg::DATA_W-1:0]          cfg_data
);

  logic signed [pbsc_pkg::DATA_W-1:0] normal_x_r, normal_y_r, normal_z_r, offset_d_r;
  logic signed [pbsc_pkg::DATA_W-1:0] normal_x_nxt, normal_y_nxt, normal_z_nxt;
  logic signed [pbsc_pkg::DATA_W-1:0] offset_d_nxt;

  logic s1_valid_r, s2_valid_r, out_valid_r;
  logic rdy1, rdy2, rdy3;
  pbsc_pkg::pbsc_adv_t adv;

  logic                               sphere;
  logic signed [pbsc_pkg::DATA_W-1:0] near_x, near_y, near_z, far_x, far_y, far_z;
  logic signed [pbsc_pkg::K_W-1:0]    k_near, k_far;
  logic                               near_gt, near_lt, far_gt, far_lt;
  pbsc_pkg::cls_t                     cls_nxt, cls_r;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_comb begin
    normal_x_nxt = normal_x_r;
    normal_y_nxt = normal_y_r;
    normal_z_nxt = normal_z_r;
    offset_d_nxt = offset_d_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        pbsc_pkg::REG_NORMAL_X: normal_x_nxt = $signed(cfg_data);
        pbsc_pkg::REG_NORMAL_Y: normal_y_nxt = $signed(cfg_data);
        pbsc_pkg::REG_NORMAL_Z: normal_z_nxt = $signed(cfg_data);
        pbsc_pkg::REG_OFFSET_D: offset_d_nxt = $signed(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      normal_x_r <= '0;
      normal_y_r <= '0;
      normal_z_r <= '0;
      offset_d_r <= '0;
    end else begin
      normal_x_r <= normal_x_nxt;
      normal_y_r <= normal_y_nxt;
      normal_z_r <= normal_z_nxt;
      offset_d_r <= offset_d_nxt;
    end
  end

  // Pipeline flow control.
  assign rdy3     = !out_valid_r || out_ready;
  assign rdy2     = !s2_valid_r || rdy3;
  assign rdy1     = !s1_valid_r || rdy2;
  assign in_ready = rdy1;
  assign adv.s1   = rdy1;
  assign adv.s2   = rdy2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1) s1_valid_r  <= in_valid;
      if (rdy2) s2_valid_r  <= s1_valid_r;
      if (rdy3) out_valid_r <= s2_valid_r;
    end
  end

  // For a sphere both evaluators see the centre; the radius moves the offset.
  assign sphere = (in_operation == pbsc_pkg::OP_SPHERE);

  assign near_x = (sphere || !normal_x_r[pbsc_pkg::DATA_W-1]) ? in_lo_or_centre_x : in_box_hi_x;
  assign near_y = (sphere || !normal_y_r[pbsc_pkg::DATA_W-1]) ? in_lo_or_centre_y : in_box_hi_y;
  assign near_z = (sphere || !normal_z_r[pbsc_pkg::DATA_W-1]) ? in_lo_or_centre_z : in_box_hi_z;
  assign far_x  = (!sphere && !normal_x_r[pbsc_pkg::DATA_W-1]) ? in_box_hi_x : in_lo_or_centre_x;
  assign far_y  = (!sphere && !normal_y_r[pbsc_pkg::DATA_W-1]) ? in_box_hi_y : in_lo_or_centre_y;
  assign far_z  = (!sphere && !normal_z_r[pbsc_pkg::DATA_W-1]) ? in_box_hi_z : in_lo_or_centre_z;

  assign k_near = sphere
    ? pbsc_pkg::K_W'(offset_d_r) - pbsc_pkg::K_W'(in_sphere_radius)
    : pbsc_pkg::K_W'(offset_d_r);
  assign k_far  = sphere
    ? pbsc_pkg::K_W'(offset_d_r) + pbsc_pkg::K_W'(in_sphere_radius)
    : pbsc_pkg::K_W'(offset_d_r);

  pbsc_plane_eval u_near (
    .clk     (clk),
    .adv     (adv),
    .nrm_x   (normal_x_r),
    .nrm_y   (normal_y_r),
    .nrm_z   (normal_z_r),
    .pt_x    (near_x),
    .pt_y    (near_y),
    .pt_z    (near_z),
    .k       (k_near),
    .gt_zero (near_gt),
    .lt_zero (near_lt)
  );

  pbsc_plane_eval u_far (
    .clk     (clk),
    .adv     (adv),
    .nrm_x   (normal_x_r),
    .nrm_y   (normal_y_r),
    .nrm_z   (normal_z_r),
    .pt_x    (far_x),
    .pt_y    (far_y),
    .pt_z    (far_z),
    .k       (k_far),
    .gt_zero (far_gt),
    .lt_zero (far_lt)
  );

  always_comb begin
    if (near_gt) begin
      cls_nxt = pbsc_pkg::CLS_FRONT;
    end else if (far_lt) begin
      cls_nxt = pbsc_pkg::CLS_BACK;
    end else begin
      cls_nxt = pbsc_pkg::CLS_INTERSECTING;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) cls_r <= cls_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_classification = cls_r;

`ifndef SYNTHESIS
  // A plane sum is never both positive and negative.
  a_sign_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r |-> !(near_gt && near_lt) && !(far_gt && far_lt))
    else $error("plane sum flagged both positive and negative");

  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> s1_valid_r)
    else $error("accepted transfer did not enter the first stage");

  a_hold_stage1: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !rdy2) |=> s1_valid_r)
    else $error("stalled first stage lost its item");

  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && s2_valid_r && out_valid_r))
    else $error("input blocked while the pipeline has a free stage");
`endif

endmodule

`default_nettype wire
